// ----- sv/rsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rsi_pkg
// Widths, constants and sequencer state type for the Wilder RSI block.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int PRICE_W      = 32;
    localparam int FRAC_W       = 16;
    localparam int ACC_W        = PRICE_W + FRAC_W;      // accumulator width
    localparam int PERIOD_W     = 11;
    localparam int K_W          = PERIOD_W - 1;          // period - 1
    localparam int MAX_PERIOD   = 1024;
    localparam int PERIOD_RESET = 14;
    localparam int RSI_W        = 15;
    localparam int RSI_FULL     = 25600;                 // 100.0 in Q7.8
    localparam int MUL_B_W      = RSI_W;                 // multiplier B operand
    localparam int PROD_W       = ACC_W + MUL_B_W;
    localparam int NUM_W        = ACC_W + FRAC_W;        // dividend width
    localparam int DEN_W        = ACC_W + 1;             // divisor / remainder
    localparam int CNT_W        = $clog2(NUM_W + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_RMUL  = 7'b0010000,
        S_RLOAD = 7'b0100000,
        S_RDIV  = 7'b1000000
    } t_state;

endpackage

// ----- sv/rsi_in_if.sv -----
// ----------------------------------------------------------------------------
// rsi_in_if
// Price sample channel: valid/ready handshake with price and series start.
// ----------------------------------------------------------------------------
interface rsi_in_if;
    import rsi_pkg::*;

    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] price;
    logic               series_start;

    modport source (output valid, price, series_start, input ready);
    modport sink   (input valid, price, series_start, output ready);

endinterface

// ----- sv/rsi_out_if.sv -----
// ----------------------------------------------------------------------------
// rsi_out_if
// Result channel: valid/ready handshake with RSI valid flag and Q7.8 value.
// ----------------------------------------------------------------------------
interface rsi_out_if;
    import rsi_pkg::*;

    logic             valid;
    logic             ready;
    logic             rsi_valid;
    logic [RSI_W-1:0] rsi_value;

    modport source (output valid, rsi_valid, rsi_value, input ready);
    modport sink   (input valid, rsi_valid, rsi_value, output ready);

endinterface

// ----- sv/relative_strength_index.sv -----
// ----------------------------------------------------------------------------
// relative_strength_index
// Wilder RSI over a stream of prices, one shared multiplier and one radix-2
// restoring divider stepped by a small sequencer.
// ----------------------------------------------------------------------------
//  channel     dir  payload                        handshake
//  i_sample    in   price[31:0], series_start       valid/ready
//  o_result    out  rsi_valid, rsi_value[14:0]      valid/ready
//  i_cfg_wr_*  in   period_length[10:0]             write enable only
//
//  Series start or warm-up sample: result valid the cycle after the accept.
//  Warm-up completing and smoothing samples run the sequencer: the divider
//  takes 64 one-bit steps per average (gain, then loss), then 15 steps for
//  the RSI ratio, which a zero loss average skips.
//  Synchronous active-low reset clears state and sets period to 14.
//  One transaction in flight; a waiting result stalls input unless taken.
// ----------------------------------------------------------------------------
module relative_strength_index (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [rsi_pkg::PERIOD_W-1:0]  i_cfg_wr_data,
    rsi_in_if.sink                        i_sample,
    rsi_out_if.source                     o_result
);
    import rsi_pkg::*;

    t_state               r_state, n_state;
    logic [PERIOD_W-1:0]  r_period, n_period;
    logic [PRICE_W-1:0]   r_prev, n_prev;
    logic [PERIOD_W-1:0]  r_idx, n_idx;
    logic [ACC_W-1:0]     r_gain, n_gain;
    logic [ACC_W-1:0]     r_loss, n_loss;
    logic [PRICE_W-1:0]   r_gx, n_gx;
    logic [PRICE_W-1:0]   r_lx, n_lx;
    logic                 r_smooth, n_smooth;
    logic                 r_sel, n_sel;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic [NUM_W-1:0]     r_num, n_num;
    logic [DEN_W-1:0]     r_rem, n_rem;
    logic [DEN_W-1:0]     r_den, n_den;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_ov, n_ov;
    logic                 r_ov_rsi, n_ov_rsi;
    logic [RSI_W-1:0]     r_ov_val, n_ov_val;

    logic [PERIOD_W-1:0]  w_p, w_p1, w_idx_c, w_idx_n;
    logic [K_W-1:0]       w_k;
    logic                 w_accept;
    logic [PRICE_W-1:0]   w_gain_x, w_loss_x, w_x_sel;
    logic [ACC_W-1:0]     w_gain_acc, w_loss_acc, w_avg_sel;
    logic [ACC_W-1:0]     w_mul_a;
    logic [MUL_B_W-1:0]   w_mul_b;
    logic [PROD_W-1:0]    w_prod;
    logic [DEN_W:0]       w_rem_sh;
    logic                 w_ge;
    logic [DEN_W:0]       w_rem_sub;
    logic [NUM_W-1:0]     w_num_step;

    // effective period: 0 acts as 1, clipped to the maximum
    always_comb begin
        if (r_period == '0) begin
            w_p = PERIOD_W'(1);
        end else if (r_period > PERIOD_W'(MAX_PERIOD)) begin
            w_p = PERIOD_W'(MAX_PERIOD);
        end else begin
            w_p = r_period;
        end
    end

    assign w_p1     = w_p + PERIOD_W'(1);
    assign w_k      = K_W'(w_p - PERIOD_W'(1));
    assign w_idx_c  = (r_idx > w_p1) ? w_p1 : r_idx;
    assign w_idx_n  = w_idx_c + PERIOD_W'(1);
    assign w_accept = i_sample.valid && i_sample.ready;

    assign w_gain_x = (i_sample.price > r_prev) ? (i_sample.price - r_prev) : '0;
    assign w_loss_x = (i_sample.price > r_prev) ? '0 : (r_prev - i_sample.price);
    assign w_gain_acc = r_gain + ACC_W'(w_gain_x);
    assign w_loss_acc = r_loss + ACC_W'(w_loss_x);

    assign w_avg_sel = r_sel ? r_loss : r_gain;
    assign w_x_sel   = r_sel ? r_lx : r_gx;

    // shared multiplier: avg * (period - 1), or gain average * 25600
    assign w_mul_a = (r_state == S_RMUL) ? r_gain : w_avg_sel;
    assign w_mul_b = (r_state == S_RMUL) ? MUL_B_W'(RSI_FULL) : MUL_B_W'(w_k);
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // shared divider step, one quotient bit per cycle
    assign w_rem_sh   = {r_rem, r_num[NUM_W-1]};
    assign w_ge       = w_rem_sh >= {1'b0, r_den};
    assign w_rem_sub  = w_rem_sh - {1'b0, r_den};
    assign w_num_step = {r_num[NUM_W-2:0], w_ge};

    always_comb begin
        n_state  = r_state;
        n_period = r_period;
        n_prev   = r_prev;
        n_idx    = r_idx;
        n_gain   = r_gain;
        n_loss   = r_loss;
        n_gx     = r_gx;
        n_lx     = r_lx;
        n_smooth = r_smooth;
        n_sel    = r_sel;
        n_prod   = r_prod;
        n_num    = r_num;
        n_rem    = r_rem;
        n_den    = r_den;
        n_cnt    = r_cnt;
        n_ov     = r_ov;
        n_ov_rsi = r_ov_rsi;
        n_ov_val = r_ov_val;

        if (i_cfg_wr_en) begin
            n_period = i_cfg_wr_data;
        end
        if (o_result.valid && o_result.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_prev = i_sample.price;
                    n_gx   = w_gain_x;
                    n_lx   = w_loss_x;
                    n_sel  = 1'b0;
                    if (i_sample.series_start) begin
                        n_idx    = '0;
                        n_gain   = '0;
                        n_loss   = '0;
                        n_ov     = 1'b1;
                        n_ov_rsi = 1'b0;
                        n_ov_val = '0;
                    end else if (w_idx_c >= w_p) begin
                        n_idx    = w_p1;
                        n_smooth = 1'b1;
                        n_state  = S_MUL;
                    end else begin
                        n_gain = w_gain_acc;
                        n_loss = w_loss_acc;
                        n_idx  = w_idx_n;
                        if (w_idx_n == w_p) begin
                            n_smooth = 1'b0;
                            n_state  = S_LOAD;
                        end else begin
                            n_ov     = 1'b1;
                            n_ov_rsi = 1'b0;
                            n_ov_val = '0;
                        end
                    end
                end
            end
            S_MUL: begin
                n_prod  = w_prod;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (r_smooth) begin
                    n_num = NUM_W'(r_prod) + {(NUM_W-PRICE_W-FRAC_W)'(0), w_x_sel, FRAC_W'(0)};
                end else begin
                    n_num = {w_avg_sel, FRAC_W'(0)};
                end
                n_rem   = '0;
                n_den   = DEN_W'(w_p);
                n_cnt   = CNT_W'(NUM_W);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_num = w_num_step;
                n_rem = w_ge ? w_rem_sub[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    if (r_sel) begin
                        n_loss  = w_num_step[ACC_W-1:0];
                        n_state = S_RMUL;
                    end else begin
                        n_gain  = w_num_step[ACC_W-1:0];
                        n_sel   = 1'b1;
                        n_state = r_smooth ? S_MUL : S_LOAD;
                    end
                end
            end
            S_RMUL: begin
                if (r_loss == '0) begin
                    n_ov     = 1'b1;
                    n_ov_rsi = 1'b1;
                    n_ov_val = RSI_W'(RSI_FULL);
                    n_state  = S_IDLE;
                end else begin
                    n_prod  = w_prod;
                    n_state = S_RLOAD;
                end
            end
            S_RLOAD: begin
                // quotient fits RSI_W bits, so the top of the product is
                // already below the divisor and seeds the remainder
                n_den   = {1'b0, r_gain} + {1'b0, r_loss};
                n_rem   = DEN_W'(r_prod[PROD_W-1:RSI_W]);
                n_num   = {r_prod[RSI_W-1:0], (NUM_W-RSI_W)'(0)};
                n_cnt   = CNT_W'(RSI_W);
                n_state = S_RDIV;
            end
            S_RDIV: begin
                n_num = w_num_step;
                n_rem = w_ge ? w_rem_sub[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_ov     = 1'b1;
                    n_ov_rsi = 1'b1;
                    n_ov_val = w_num_step[RSI_W-1:0];
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_period <= PERIOD_W'(PERIOD_RESET);
            r_prev   <= '0;
            r_idx    <= '0;
            r_gain   <= '0;
            r_loss   <= '0;
            r_smooth <= 1'b0;
            r_sel    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_period <= n_period;
            r_prev   <= n_prev;
            r_idx    <= n_idx;
            r_gain   <= n_gain;
            r_loss   <= n_loss;
            r_smooth <= n_smooth;
            r_sel    <= n_sel;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gx     <= n_gx;
        r_lx     <= n_lx;
        r_prod   <= n_prod;
        r_num    <= n_num;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_cnt    <= n_cnt;
        r_ov_rsi <= n_ov_rsi;
        r_ov_val <= n_ov_val;
    end

    // output register frees up in the same cycle its transaction is taken
    assign i_sample.ready     = (r_state == S_IDLE) && (!r_ov || o_result.ready);
    assign o_result.valid     = r_ov;
    assign o_result.rsi_valid = r_ov_rsi;
    assign o_result.rsi_value = r_ov_val;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_result.valid || (r_state != S_IDLE)))
        else $error("accepted transaction produced neither result nor work");

    a_rsi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.rsi_value <= RSI_W'(RSI_FULL)))
        else $error("rsi value above full scale");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.rsi_valid) |-> (o_result.rsi_value == '0))
        else $error("invalid result carries nonzero value");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) || (r_state == S_RDIV)) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

endmodule
